// ----- src/active_lattice_gas_hop_step_assert.svh -----
// Assertion macros for the checker of the lattice gas block.
`ifndef ACTIVE_LATTICE_GAS_HOP_STEP_ASSERT_SVH
`define ACTIVE_LATTICE_GAS_HOP_STEP_ASSERT_SVH

// cond in this cycle implies expr in the same cycle
`define ALGH_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("algh check failed");

// cond in this cycle implies expr in the next cycle
`define ALGH_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("algh check failed");

`endif

// ----- src/algh_pkg.sv -----
package algh_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int SITES      = MAX_WIDTH * MAX_HEIGHT;
    localparam int MIN_DIM    = 2;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WUW = $clog2(MAX_WIDTH + 1);
    localparam int HUW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(SITES);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_DIM_W  = 9;
    localparam int CFG_THR_W  = 17;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_REJECT_ONE  = 3'd2,
        CFG_REJECT_TWO  = 3'd3,
        CFG_REJECT_THREE = 3'd4,
        CFG_TURN        = 3'd5,
        CFG_ACTIVE      = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_HOP   = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DIR_PX = 2'd0,
        DIR_PY = 2'd1,
        DIR_MX = 2'd2,
        DIR_MY = 2'd3
    } dir_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } coord_t;

    typedef struct packed {
        logic       occ;
        logic [1:0] dir;
    } site_t;

    function automatic logic [WUW-1:0] clamp_w(logic [CFG_DIM_W-1:0] v);
        if (32'(v) < MIN_DIM) return WUW'(MIN_DIM);
        if (32'(v) > MAX_WIDTH) return WUW'(MAX_WIDTH);
        return WUW'(v);
    endfunction

    function automatic logic [HUW-1:0] clamp_h(logic [CFG_DIM_W-1:0] v);
        if (32'(v) < MIN_DIM) return HUW'(MIN_DIM);
        if (32'(v) > MAX_HEIGHT) return HUW'(MAX_HEIGHT);
        return HUW'(v);
    endfunction

    // one periodic step on the lattice
    function automatic coord_t step_xy(coord_t c, logic [1:0] dir,
                                       logic [WUW-1:0] w, logic [HUW-1:0] h);
        coord_t         n;
        logic [WUW-1:0] xp;
        logic [HUW-1:0] yp;
        n  = c;
        xp = WUW'(c.x) + WUW'(1);
        yp = HUW'(c.y) + HUW'(1);
        unique case (dir_t'(dir))
            DIR_PX: n.x = (xp == w) ? '0 : XW'(xp);
            DIR_PY: n.y = (yp == h) ? '0 : YW'(yp);
            DIR_MX: n.x = (c.x == '0) ? XW'(w - WUW'(1)) : c.x - XW'(1);
            DIR_MY: n.y = (c.y == '0) ? YW'(h - HUW'(1)) : c.y - YW'(1);
        endcase
        return n;
    endfunction

    function automatic logic [AW-1:0] addr_of(coord_t c);
        return AW'(AW'(c.y) * AW'(MAX_WIDTH) + AW'(c.x));
    endfunction

endpackage

// ----- src/active_lattice_gas_hop_step.sv -----
// Active lattice gas hop engine. Holds a periodic lattice of sites (occupancy
// bit plus 2-bit heading) in one single-port memory and runs one item at a
// time: a hop attempt (mode 0), a site write (mode 1) or a site read (mode 2;
// mode 3 reads too). All lattice traffic goes through the one memory port, one
// access per cycle, and one shared wrap/step unit forms every neighbour
// address. A hop that goes ahead reads the site, the target and eight
// neighbours, decides, writes the target and then the site, and gives its
// result; a hop that is undone skips the target write; a blocked or
// empty-site hop writes the site back without neighbour reads; a read
// reads the site, a write writes it, and an off-grid item goes to the result.
// After reset a clearing pass writes every one of the MAX_WIDTH*MAX_HEIGHT
// sites and s_tready stays low until it ends; configuration writes are
// taken throughout. A finished result sits in the output register, so the
// next item can be accepted while it waits.
// Write configuration only while the block is idle.
module active_lattice_gas_hop_step import algh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // site_x[7:0], site_y[15:8], drawn_direction[17:16], accept_draw[33:18],
    // turn_draw[49:34], turn_offset[51:50], write_occupied[52],
    // write_direction[54:53], zero pad[55]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hopped[0], target_x[8:1], target_y[16:9], site_occupied[17],
    // site_direction[19:18], zero pad[23:20]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic [M_TUSER_W-1:0]  m_tuser
);

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_SITE    = 9'b000000100,  // site word back, read target
        ST_TGT     = 9'b000001000,  // target word back
        ST_NBR     = 9'b000010000,  // eight neighbour reads
        ST_DECIDE  = 9'b000100000,  // undo test
        ST_WR_TGT  = 9'b001000000,
        ST_WR_SITE = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    // configuration registers
    logic [CFG_DIM_W-1:0] grid_width_reg, grid_height_reg;
    logic [CFG_THR_W-1:0] rej_one_reg, rej_two_reg, rej_three_reg, turn_thr_reg;
    logic                 active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= CFG_DIM_W'(MAX_WIDTH);
            grid_height_reg <= CFG_DIM_W'(MAX_HEIGHT);
            rej_one_reg     <= '0;
            rej_two_reg     <= '0;
            rej_three_reg   <= '0;
            turn_thr_reg    <= '0;
            active_reg      <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:   grid_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_HEIGHT:  grid_height_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_REJECT_ONE:   rej_one_reg     <= cfg_data[CFG_THR_W-1:0];
                CFG_REJECT_TWO:   rej_two_reg     <= cfg_data[CFG_THR_W-1:0];
                CFG_REJECT_THREE: rej_three_reg   <= cfg_data[CFG_THR_W-1:0];
                CFG_TURN:         turn_thr_reg    <= cfg_data[CFG_THR_W-1:0];
                CFG_ACTIVE:       active_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [WUW-1:0] w_use;
    logic [HUW-1:0] h_use;
    assign w_use = clamp_w(grid_width_reg);
    assign h_use = clamp_h(grid_height_reg);

    // input fields
    logic [7:0]  in_x, in_y;
    logic [1:0]  in_mode;
    coord_t      in_c;
    assign in_mode = s_tuser[1:0];
    assign in_x    = s_tdata[7:0];
    assign in_y    = s_tdata[15:8];
    assign in_c.x  = XW'(in_x);
    assign in_c.y  = YW'(in_y);

    // state
    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [3:0]     k_reg, k_next;          // neighbour read counter
    logic           pend_reg, pend_next;    // neighbour word due this cycle
    logic           m_tvalid_reg, m_tvalid_next;

    // item payload and working registers
    logic [1:0]     mode_reg, mode_next;
    coord_t         site_reg, site_next;
    coord_t         tgt_reg, tgt_next;
    logic [AW-1:0]  si_reg, si_next;
    logic [AW-1:0]  ti_reg, ti_next;
    logic [1:0]     ddir_reg, ddir_next;
    logic [15:0]    adraw_reg, adraw_next;
    logic [15:0]    tdraw_reg, tdraw_next;
    logic [1:0]     toff_reg, toff_next;
    site_t          wsite_reg, wsite_next;
    site_t          orig_reg, orig_next;     // chosen site before the item
    logic [1:0]     tgt_dir_reg, tgt_dir_next;
    logic [2:0]     ni_reg, ni_next;
    logic [2:0]     nj_reg, nj_next;
    logic           nj_sel_reg, nj_sel_next;
    logic           zero_reg, zero_next;     // neighbour is the vacated site
    logic           status_reg, status_next;
    logic           hopped_reg, hopped_next;
    site_t          fin_reg, fin_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // memory port
    site_t          mem [SITES];
    site_t          rdata_reg;
    logic [AW-1:0]  mem_addr;
    logic           mem_we;
    site_t          mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // shared step unit
    coord_t         step_c, step_n;
    logic [1:0]     step_dir;
    logic [AW-1:0]  step_addr;
    assign step_n    = step_xy(step_c, step_dir, w_use, h_use);
    assign step_addr = addr_of(step_n);

    logic           off_grid;
    logic [2:0]     diff;
    logic [CFG_THR_W-1:0] undo_thr;
    logic           undo;
    logic           turn;
    site_t          site_word;

    assign off_grid = (32'(in_x) >= 32'(w_use)) || (32'(in_y) >= 32'(h_use));
    assign diff     = ni_reg - nj_reg;
    always_comb begin
        priority if (diff == 3'd1) undo_thr = rej_one_reg;
        else if (diff == 3'd2)     undo_thr = rej_two_reg;
        else                       undo_thr = rej_three_reg;
    end
    assign undo = (ni_reg > nj_reg) && (CFG_THR_W'(adraw_reg) < undo_thr);
    assign turn = active_reg && (CFG_THR_W'(tdraw_reg) < turn_thr_reg);

    // final word of the chosen site for write and hop items
    always_comb begin
        if (mode_reg == MODE_WRITE) begin
            site_word = wsite_reg;
        end else begin
            site_word.occ = orig_reg.occ && !hopped_reg;
            site_word.dir = turn ? (orig_reg.dir + 2'd1 + toff_reg) : orig_reg.dir;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        k_next        = k_reg;
        pend_next     = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mode_next     = mode_reg;
        site_next     = site_reg;
        tgt_next      = tgt_reg;
        si_next       = si_reg;
        ti_next       = ti_reg;
        ddir_next     = ddir_reg;
        adraw_next    = adraw_reg;
        tdraw_next    = tdraw_reg;
        toff_next     = toff_reg;
        wsite_next    = wsite_reg;
        orig_next     = orig_reg;
        tgt_dir_next  = tgt_dir_reg;
        ni_next       = ni_reg;
        nj_next       = nj_reg;
        nj_sel_next   = nj_sel_reg;
        zero_next     = zero_reg;
        status_next   = status_reg;
        hopped_next   = hopped_reg;
        fin_next      = fin_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_addr      = si_reg;
        mem_we        = 1'b0;
        mem_wdata     = '0;
        step_c        = site_reg;
        step_dir      = k_reg[1:0];

        // neighbour word arrives in the cycle after its read
        if (pend_reg) begin
            if (nj_sel_reg) begin
                nj_next = nj_reg + 3'(rdata_reg.occ && !zero_reg);
            end else begin
                ni_next = ni_reg + 3'(rdata_reg.occ);
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(SITES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mem_addr = addr_of(in_c);   // site read goes out with the accept
                if (s_tvalid) begin
                    mode_next   = in_mode;
                    site_next   = in_c;
                    si_next     = addr_of(in_c);
                    ddir_next   = s_tdata[17:16];
                    adraw_next  = s_tdata[33:18];
                    tdraw_next  = s_tdata[49:34];
                    toff_next   = s_tdata[51:50];
                    wsite_next  = {s_tdata[52], s_tdata[54:53]};
                    tgt_next    = '0;
                    status_next = off_grid;
                    hopped_next = 1'b0;
                    fin_next    = '0;
                    priority if (off_grid)        state_next = ST_OUT;
                    else if (in_mode == MODE_WRITE) state_next = ST_WR_SITE;
                    else                          state_next = ST_SITE;
                end
            end
            ST_SITE: begin
                orig_next = rdata_reg;
                if (mode_reg == MODE_HOP) begin
                    step_dir   = active_reg ? rdata_reg.dir : ddir_reg;
                    mem_addr   = step_addr;
                    tgt_next   = step_n;
                    ti_next    = step_addr;
                    state_next = ST_TGT;
                end else begin
                    fin_next   = rdata_reg;
                    state_next = ST_OUT;
                end
            end
            ST_TGT: begin
                tgt_dir_next = rdata_reg.dir;
                ni_next      = '0;
                nj_next      = '0;
                k_next       = '0;
                if (orig_reg.occ && !rdata_reg.occ) begin
                    state_next = ST_NBR;
                end else begin
                    state_next = ST_WR_SITE;
                end
            end
            ST_NBR: begin
                // counts 0..3 walk the site, 4..7 the target
                step_c = k_reg[2] ? tgt_reg : site_reg;
                if (!k_reg[3]) begin
                    mem_addr    = step_addr;
                    pend_next   = 1'b1;
                    nj_sel_next = k_reg[2];
                    zero_next   = k_reg[2] && (step_addr == si_reg);
                    k_next      = k_reg + 4'd1;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                hopped_next = !undo;
                state_next  = undo ? ST_WR_SITE : ST_WR_TGT;
            end
            ST_WR_TGT: begin
                mem_addr   = ti_reg;
                mem_we     = 1'b1;
                mem_wdata  = {1'b1, tgt_dir_reg};
                state_next = ST_WR_SITE;
            end
            ST_WR_SITE: begin
                mem_addr   = si_reg;
                mem_we     = 1'b1;
                mem_wdata  = site_word;
                fin_next   = site_word;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = M_TUSER_W'(status_reg);
                    m_tdata_next  = {4'b0, fin_reg.dir, fin_reg.occ,
                                     8'(tgt_reg.y), 8'(tgt_reg.x), hopped_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            k_reg        <= k_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        site_reg    <= site_next;
        tgt_reg     <= tgt_next;
        si_reg      <= si_next;
        ti_reg      <= ti_next;
        ddir_reg    <= ddir_next;
        adraw_reg   <= adraw_next;
        tdraw_reg   <= tdraw_next;
        toff_reg    <= toff_next;
        wsite_reg   <= wsite_next;
        orig_reg    <= orig_next;
        tgt_dir_reg <= tgt_dir_next;
        ni_reg      <= ni_next;
        nj_reg      <= nj_next;
        nj_sel_reg  <= nj_sel_next;
        zero_reg    <= zero_next;
        status_reg  <= status_next;
        hopped_reg  <= hopped_next;
        fin_reg     <= fin_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- src/algh_checker.sv -----
`include "active_lattice_gas_hop_step_assert.svh"

module algh_checker import algh_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // stalled result holds
    `ALGH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // one item at a time: busy right after an accept
    `ALGH_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // off-grid result carries nothing else
    `ALGH_ASSERT_NOW(a_off_grid_clean, m_tvalid && m_tuser[0], m_tdata == '0)
    // a particle that hopped has left the chosen site
    `ALGH_ASSERT_NOW(a_hop_leaves_site, m_tvalid && m_tdata[0], !m_tdata[17])

endmodule

bind active_lattice_gas_hop_step algh_checker u_algh_checker (.*);
